[hw/rtl/psd_pkg.sv]
package psd_pkg;

   // Field widths of the request and response items.
   localparam int SAMPLE_BITS = 16;
   localparam int DIST_BITS   = 48;
   localparam int COUNT_BITS  = 24;
   localparam int CENTRE_BITS = 10;
   localparam int HALF_BITS   = 5;
   localparam int EXTENT_BITS = 11;
   localparam int WEIGHT_BITS = 17;
   localparam int CODE_BITS   = 2;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 17;

   localparam logic [CSR_INDEX_BITS-1:0] REG_CONDITIONAL_MODE = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HARD_DATA_WEIGHT = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HALF_SIZE_X      = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HALF_SIZE_Y      = 4'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HALF_SIZE_Z      = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TRAIN_LENGTH     = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TRAIN_WIDTH      = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TRAIN_HEIGHT     = 4'd7;

   // Register values after reset.
   localparam logic                   RESET_MODE   = 1'b0;
   localparam logic [WEIGHT_BITS-1:0] RESET_WEIGHT = 17'd32768;
   localparam logic [HALF_BITS-1:0]   RESET_HALF_X = 5'd2;
   localparam logic [HALF_BITS-1:0]   RESET_HALF_Y = 5'd2;
   localparam logic [HALF_BITS-1:0]   RESET_HALF_Z = 5'd0;
   localparam logic [EXTENT_BITS-1:0] RESET_LENGTH = 11'd1024;
   localparam logic [EXTENT_BITS-1:0] RESET_WIDTH  = 11'd1024;
   localparam logic [EXTENT_BITS-1:0] RESET_HEIGHT = 11'd1;

   // Unity in the Q16 weight format.
   localparam logic [WEIGHT_BITS-1:0] Q16_ONE = 17'h10000;

   // Outcome codes, also used for the held verdict.
   localparam logic [CODE_BITS-1:0] OUTCOME_COMPUTED = 2'd0;
   localparam logic [CODE_BITS-1:0] OUTCOME_BORDER   = 2'd1;
   localparam logic [CODE_BITS-1:0] OUTCOME_ABOVE    = 2'd2;

   // Defaults of the geometry parameters.
   localparam int GRID_DIM_DEFAULT = 1024;
   localparam int MAX_HALF_DEFAULT = 31;

   typedef struct packed {
      logic                          first_element;
      logic                          last_element;
      logic [CENTRE_BITS-1:0]        centre_x;
      logic [CENTRE_BITS-1:0]        centre_y;
      logic [CENTRE_BITS-1:0]        centre_z;
      logic [DIST_BITS-1:0]          reject_limit;
      logic signed [SAMPLE_BITS-1:0] real_sample;
      logic signed [SAMPLE_BITS-1:0] train_sample;
      logic signed [SAMPLE_BITS-1:0] hard_sample;
      logic                          hard_known;
   } req_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] distance;
      logic [CODE_BITS-1:0] outcome;
   } rsp_type;

endpackage

[hw/rtl/patch_ssd_distance_unit.sv]
// Patch distance unit. Elements of one patch comparison arrive as items on the req_ channel:
// the first item carries the candidate centre and the rejection limit, the last one makes the
// block emit a single response carrying the distance and an outcome code (computed, centre
// too close to the training-image border, or sum above the limit, the latter two with an
// all-ones distance). Sums, products, divisions and the limit comparison share one 50-bit
// adder/subtractor under a small sequencer: each squared difference is a 17-step shift-add
// multiplication; in conditional mode the last item also takes up to two 48-step restoring
// divisions for the means and, with hard data, two 17-step multiplications for the Q16 blend.
// Each item runs load, prepare, square, accumulate, compare (not in conditional mode) and
// done, or prepare and done once rejected; a last item then reaches the output stage, in
// conditional mode through the divisions and blend. No item is taken until the block is
// idle. The response sits in an output register, so a waiting response only holds the block
// when the next result is ready to be written. Configuration writes are always accepted and
// must only be issued while the block is idle. There is no clearing pass after reset.
module patch_ssd_distance_unit #(
   parameter int GRID_DIM = psd_pkg::GRID_DIM_DEFAULT,
   parameter int MAX_HALF = psd_pkg::MAX_HALF_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  psd_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output psd_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [psd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [psd_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int DW        = psd_pkg::DIST_BITS;
   localparam int CW        = psd_pkg::COUNT_BITS;
   localparam int WW        = psd_pkg::WEIGHT_BITS;
   localparam int SW        = psd_pkg::SAMPLE_BITS;
   localparam int ALU_W     = DW + 2;
   localparam int STEP_W    = $clog2(DW + 1);
   localparam int GRID_BITS = $clog2(GRID_DIM + 1);
   localparam int GEO_W     = ((GRID_BITS > psd_pkg::EXTENT_BITS) ?
                               GRID_BITS : psd_pkg::EXTENT_BITS) + 2;

   localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(WW);
   localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(DW);

   // Sequencer states.
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LOAD = 4'd1;
   localparam logic [3:0] S_PREP = 4'd2;
   localparam logic [3:0] S_SQR  = 4'd3;
   localparam logic [3:0] S_ACC  = 4'd4;
   localparam logic [3:0] S_CMP  = 4'd5;
   localparam logic [3:0] S_DONE = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_MULF = 4'd8;
   localparam logic [3:0] S_MULH = 4'd9;
   localparam logic [3:0] S_SUM  = 4'd10;
   localparam logic [3:0] S_OUT  = 4'd11;

   // Configuration registers.
   logic                                mode_ff;
   logic [WW-1:0]                       weight_ff;
   logic [psd_pkg::HALF_BITS-1:0]       half_x_ff, half_y_ff, half_z_ff;
   logic [psd_pkg::EXTENT_BITS-1:0]     len_x_ff, len_y_ff, len_z_ff;

   // Control and accumulation state.
   logic [3:0]                          state_ff, state_in;
   logic [DW-1:0]                       free_sum_ff, free_sum_in;
   logic [DW-1:0]                       hard_sum_ff, hard_sum_in;
   logic [CW-1:0]                       free_cnt_ff, free_cnt_in;
   logic [CW-1:0]                       hard_cnt_ff, hard_cnt_in;
   logic [DW-1:0]                       held_limit_ff, held_limit_in;
   logic [psd_pkg::CODE_BITS-1:0]       verdict_ff, verdict_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   // Working registers of the shared unit.
   psd_pkg::req_type                    item_ff, item_in;
   logic [DW:0]                         acc_ff, acc_in;
   logic [DW:0]                         aux_ff, aux_in;
   logic [WW-1:0]                       mpl_ff, mpl_in;
   logic [STEP_W-1:0]                   step_ff, step_in;
   logic                                div_hard_ff, div_hard_in;
   logic [DW-1:0]                       fmean_ff, fmean_in;
   logic [DW-1:0]                       hmean_ff, hmean_in;
   logic [DW:0]                         term_ff, term_in;
   logic [DW-1:0]                       res_dist_ff, res_dist_in;
   logic [psd_pkg::CODE_BITS-1:0]       res_code_ff, res_code_in;
   psd_pkg::rsp_type                    rsp_ff, rsp_in;

   // Shared adder/subtractor.
   logic [DW:0]                         alu_a, alu_b;
   logic                                alu_sub;
   logic [ALU_W-1:0]                    alu_res;

   logic                                use_free;
   logic signed [SW:0]                  diff;
   logic [SW:0]                         mag;
   logic [DW-1:0]                       square;
   logic [DW:0]                         div_shift;
   logic                                qbit;
   logic [DW-1:0]                       quotient;
   logic [WW-1:0]                       w_clamped, w_other;
   logic                                border_out;
   logic                                rsp_free;

   // Returns 1 when centre c lies within h of either end of an axis of extent len.
   function automatic logic axis_outside(
      input logic [psd_pkg::CENTRE_BITS-1:0] c,
      input logic [psd_pkg::HALF_BITS-1:0]   h,
      input logic [psd_pkg::EXTENT_BITS-1:0] len
   );
      logic signed [GEO_W-1:0] cc, hh, ll, lim;
      cc  = GEO_W'(c);
      hh  = (GEO_W'(h) > GEO_W'(MAX_HALF)) ? GEO_W'(MAX_HALF) : GEO_W'(h);
      ll  = (GEO_W'(len) > GEO_W'(GRID_DIM)) ? GEO_W'(GRID_DIM) : GEO_W'(len);
      lim = ll - hh;
      return (cc < hh) || (cc >= lim);
   endfunction

   assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                            : ({1'b0, alu_a} + {1'b0, alu_b});

   assign use_free  = !mode_ff || !item_ff.hard_known;
   assign diff      = (use_free ? (SW+1)'(item_ff.real_sample) : (SW+1)'(item_ff.hard_sample))
                      - (SW+1)'(item_ff.train_sample);
   assign mag       = diff[SW] ? (SW+1)'(-diff) : (SW+1)'(diff);
   assign square    = DW'({acc_ff, mpl_ff});
   assign div_shift = {acc_ff[DW-1:0], aux_ff[DW-1]};
   assign w_clamped = (weight_ff > psd_pkg::Q16_ONE) ? psd_pkg::Q16_ONE : weight_ff;
   assign w_other   = psd_pkg::Q16_ONE - w_clamped;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign border_out = axis_outside(item_ff.centre_x, half_x_ff, len_x_ff) ||
                       axis_outside(item_ff.centre_y, half_y_ff, len_y_ff) ||
                       axis_outside(item_ff.centre_z, half_z_ff, len_z_ff);

   assign qbit     = !alu_res[ALU_W-1];
   assign quotient = {aux_ff[DW-2:0], qbit};

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      free_sum_in   = free_sum_ff;
      hard_sum_in   = hard_sum_ff;
      free_cnt_in   = free_cnt_ff;
      hard_cnt_in   = hard_cnt_ff;
      held_limit_in = held_limit_ff;
      verdict_in    = verdict_ff;
      item_in       = item_ff;
      acc_in        = acc_ff;
      aux_in        = aux_ff;
      mpl_in        = mpl_ff;
      step_in       = step_ff;
      div_hard_in   = div_hard_ff;
      fmean_in      = fmean_ff;
      hmean_in      = hmean_ff;
      term_in       = term_ff;
      res_dist_in   = res_dist_ff;
      res_code_in   = res_code_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      alu_a         = '0;
      alu_b         = '0;
      alu_sub       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = S_LOAD;
            end
         end

         S_LOAD: begin
            if (item_ff.first_element) begin
               free_sum_in   = '0;
               hard_sum_in   = '0;
               free_cnt_in   = '0;
               hard_cnt_in   = '0;
               held_limit_in = item_ff.reject_limit;
               verdict_in    = border_out ? psd_pkg::OUTCOME_BORDER
                                          : psd_pkg::OUTCOME_COMPUTED;
            end
            state_in = S_PREP;
         end

         S_PREP: begin
            if (verdict_ff != psd_pkg::OUTCOME_COMPUTED) begin
               state_in = S_DONE;
            end else begin
               aux_in   = (DW+1)'(mag);
               mpl_in   = WW'(mag);
               acc_in   = '0;
               step_in  = MUL_STEPS;
               state_in = S_SQR;
            end
         end

         S_SQR, S_MULF, S_MULH: begin
            // One shift-add step: add the multiplicand when the low multiplier bit is set,
            // then shift the double-width product right by one.
            alu_a   = acc_ff;
            alu_b   = mpl_ff[0] ? aux_ff : '0;
            acc_in  = alu_res[ALU_W-1:1];
            mpl_in  = {alu_res[0], mpl_ff[WW-1:1]};
            step_in = step_ff - 1'b1;
            if (step_ff == 1) begin
               if (state_ff == S_SQR) begin
                  state_in = S_ACC;
               end else if (state_ff == S_MULF) begin
                  // The product shifted down by 16 is exactly the adder result here.
                  term_in  = alu_res[DW:0];
                  aux_in   = (DW+1)'(hmean_ff);
                  mpl_in   = w_clamped;
                  acc_in   = '0;
                  step_in  = MUL_STEPS;
                  state_in = S_MULH;
               end else begin
                  state_in = S_SUM;
               end
            end
         end

         S_ACC: begin
            alu_a = (DW+1)'(use_free ? free_sum_ff : hard_sum_ff);
            alu_b = (DW+1)'(square);
            if (use_free) begin
               free_sum_in = (alu_res[ALU_W-1:DW] != '0) ? '1 : alu_res[DW-1:0];
               free_cnt_in = (free_cnt_ff == '1) ? free_cnt_ff : free_cnt_ff + 1'b1;
            end else begin
               hard_sum_in = (alu_res[ALU_W-1:DW] != '0) ? '1 : alu_res[DW-1:0];
               hard_cnt_in = (hard_cnt_ff == '1) ? hard_cnt_ff : hard_cnt_ff + 1'b1;
            end
            state_in = mode_ff ? S_DONE : S_CMP;
         end

         S_CMP: begin
            // A borrow from limit minus sum means the sum has passed the limit.
            alu_a   = (DW+1)'(held_limit_ff);
            alu_b   = (DW+1)'(free_sum_ff);
            alu_sub = 1'b1;
            if (alu_res[ALU_W-1]) begin
               verdict_in = psd_pkg::OUTCOME_ABOVE;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!item_ff.last_element) begin
               state_in = S_IDLE;
            end else if (verdict_ff != psd_pkg::OUTCOME_COMPUTED) begin
               res_dist_in = '1;
               res_code_in = verdict_ff;
               state_in    = S_OUT;
            end else if (!mode_ff) begin
               res_dist_in = free_sum_ff;
               res_code_in = psd_pkg::OUTCOME_COMPUTED;
               state_in    = S_OUT;
            end else if (free_cnt_ff != '0) begin
               acc_in      = '0;
               aux_in      = (DW+1)'(free_sum_ff);
               step_in     = DIV_STEPS;
               div_hard_in = 1'b0;
               state_in    = S_DIV;
            end else begin
               // An empty free region counts as a free mean of zero.
               fmean_in    = '0;
               res_code_in = psd_pkg::OUTCOME_COMPUTED;
               if (hard_cnt_ff == '0) begin
                  res_dist_in = '0;
                  state_in    = S_OUT;
               end else begin
                  acc_in      = '0;
                  aux_in      = (DW+1)'(hard_sum_ff);
                  step_in     = DIV_STEPS;
                  div_hard_in = 1'b1;
                  state_in    = S_DIV;
               end
            end
         end

         S_DIV: begin
            // Restoring division, one quotient bit per cycle.
            alu_a   = div_shift;
            alu_b   = (DW+1)'(div_hard_ff ? hard_cnt_ff : free_cnt_ff);
            alu_sub = 1'b1;
            acc_in  = qbit ? alu_res[DW:0] : div_shift;
            aux_in  = {aux_ff[DW-1:0], qbit};
            step_in = step_ff - 1'b1;
            if (step_ff == 1) begin
               res_code_in = psd_pkg::OUTCOME_COMPUTED;
               if (!div_hard_ff) begin
                  fmean_in = quotient;
                  if (hard_cnt_ff == '0) begin
                     res_dist_in = quotient;
                     state_in    = S_OUT;
                  end else begin
                     acc_in      = '0;
                     aux_in      = (DW+1)'(hard_sum_ff);
                     step_in     = DIV_STEPS;
                     div_hard_in = 1'b1;
                  end
               end else begin
                  hmean_in = quotient;
                  aux_in   = (DW+1)'(fmean_ff);
                  mpl_in   = w_other;
                  acc_in   = '0;
                  step_in  = MUL_STEPS;
                  state_in = S_MULF;
               end
            end
         end

         S_SUM: begin
            alu_a       = term_ff;
            alu_b       = {acc_ff[DW-1:0], mpl_ff[WW-1]};
            res_dist_in = (alu_res[ALU_W-1:DW] != '0) ? '1 : alu_res[DW-1:0];
            res_code_in = psd_pkg::OUTCOME_COMPUTED;
            state_in    = S_OUT;
         end

         S_OUT: begin
            if (rsp_free) begin
               rsp_in.distance = res_dist_ff;
               rsp_in.outcome  = res_code_ff;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_sum_ff   <= '0;
         hard_sum_ff   <= '0;
         free_cnt_ff   <= '0;
         hard_cnt_ff   <= '0;
         held_limit_ff <= '1;
         verdict_ff    <= psd_pkg::OUTCOME_COMPUTED;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= psd_pkg::RESET_MODE;
         weight_ff     <= psd_pkg::RESET_WEIGHT;
         half_x_ff     <= psd_pkg::RESET_HALF_X;
         half_y_ff     <= psd_pkg::RESET_HALF_Y;
         half_z_ff     <= psd_pkg::RESET_HALF_Z;
         len_x_ff      <= psd_pkg::RESET_LENGTH;
         len_y_ff      <= psd_pkg::RESET_WIDTH;
         len_z_ff      <= psd_pkg::RESET_HEIGHT;
      end else begin
         state_ff      <= state_in;
         free_sum_ff   <= free_sum_in;
         hard_sum_ff   <= hard_sum_in;
         free_cnt_ff   <= free_cnt_in;
         hard_cnt_ff   <= hard_cnt_in;
         held_limit_ff <= held_limit_in;
         verdict_ff    <= verdict_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               psd_pkg::REG_CONDITIONAL_MODE: mode_ff   <= csr_data[0];
               psd_pkg::REG_HARD_DATA_WEIGHT: weight_ff <= csr_data[WW-1:0];
               psd_pkg::REG_HALF_SIZE_X:
                  half_x_ff <= csr_data[psd_pkg::HALF_BITS-1:0];
               psd_pkg::REG_HALF_SIZE_Y:
                  half_y_ff <= csr_data[psd_pkg::HALF_BITS-1:0];
               psd_pkg::REG_HALF_SIZE_Z:
                  half_z_ff <= csr_data[psd_pkg::HALF_BITS-1:0];
               psd_pkg::REG_TRAIN_LENGTH:
                  len_x_ff <= csr_data[psd_pkg::EXTENT_BITS-1:0];
               psd_pkg::REG_TRAIN_WIDTH:
                  len_y_ff <= csr_data[psd_pkg::EXTENT_BITS-1:0];
               psd_pkg::REG_TRAIN_HEIGHT:
                  len_z_ff <= csr_data[psd_pkg::EXTENT_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      acc_ff      <= acc_in;
      aux_ff      <= aux_in;
      mpl_ff      <= mpl_in;
      step_ff     <= step_in;
      div_hard_ff <= div_hard_in;
      fmean_ff    <= fmean_in;
      hmean_ff    <= hmean_in;
      term_ff     <= term_in;
      res_dist_ff <= res_dist_in;
      res_code_ff <= res_code_in;
      rsp_ff      <= rsp_in;
   end

`ifndef SYNTH
   // A rejected comparison always reports the all-ones distance.
   a_reject_all_ones: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.outcome != psd_pkg::OUTCOME_COMPUTED)) |-> (rsp_data.distance == '1))
      else $error("rejected response without all-ones distance");

   // The block is no longer ready once it has accepted an item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("block ready again straight after accepting an item");

   // A pending result waits while the previous response is still held.
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_OUT) && rsp_valid && !rsp_ready) |=> (state_ff == S_OUT))
      else $error("result left the output stage while the response was stalled");

   // The hard-data mean is only divided out when there was hard data.
   a_hard_div_count: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DIV) && div_hard_ff) |-> (hard_cnt_ff != '0))
      else $error("hard-data division with a zero count");

   // The iteration counter never runs out inside an iterative state.
   a_step_live: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DIV) || (state_ff == S_SQR) || (state_ff == S_MULF) ||
       (state_ff == S_MULH)) |-> (step_ff != '0))
      else $error("iteration counter at zero inside an iterative state");
`endif

endmodule
